// ===== rtl/core/sjf_pkg.sv =====
// Shared types and constants for the SJF scheduler.
package sjf_pkg;

	localparam int unsigned TIME_W = 18;
	localparam int unsigned SUM_W  = 22;
	localparam logic [TIME_W-1:0] TIME_MAX = '1;
	localparam logic [SUM_W-1:0]  SUM_MAX  = '1;

	// input word
	typedef struct packed {
		logic [15:0] job_id;
		logic [15:0] arrival_time;
		logic [13:0] burst_time;
		logic        last_job;
	} job_t;

	// result word
	typedef struct packed {
		logic [15:0]       out_job_id;
		logic [TIME_W-1:0] completion_time;
		logic [TIME_W-1:0] turnaround_time;
		logic [TIME_W-1:0] waiting_time;
		logic [SUM_W-1:0]  sum_waiting;
		logic [SUM_W-1:0]  sum_turnaround;
		logic              last_result;
	} result_t;

	// back-end sequencer states
	typedef enum logic [2:0] {
		ST_LOAD,
		ST_SCAN,
		ST_APPLY,
		ST_REPORT,
		ST_EMIT
	} state_t;

endpackage

// ===== rtl/core/sjf_front.sv =====
// Front end: input queue of job words ahead of the scheduler core.
module sjf_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	output logic          full,
	input  sjf_pkg::job_t wdata,
	output logic          q_valid,
	input  logic          q_take,
	output sjf_pkg::job_t q_data
);
	import sjf_pkg::*;

	// two-entry queue
	job_t       mem_q [2];
	logic       wptr_q, rptr_q;
	logic [1:0] cnt_q;

	assign full    = (cnt_q == 2'd2);
	assign q_valid = (cnt_q != 2'd0);
	assign q_data  = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push && !full) mem_q[wptr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (push && !full) wptr_q <= ~wptr_q;
			if (q_take && q_valid) rptr_q <= ~rptr_q;
			cnt_q <= cnt_q + 2'((push && !full) ? 1 : 0) - 2'((q_take && q_valid) ? 1 : 0);
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= 2'd2)
		else $error("queue count overflow");
	assert property (@(posedge clk) disable iff (!arst_n)
		(full && !(q_take && q_valid)) |=> full)
		else $error("full dropped without a take");
	assert property (@(posedge clk) disable iff (!arst_n) !(full && !q_valid))
		else $error("full but empty");
endmodule

// ===== rtl/core/sjf_core.sv =====
// Back end: job store, SJF selection scan and result emission.
module sjf_core #(
	parameter int unsigned MAX_PROCS = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_valid,
	output logic             q_take,
	input  sjf_pkg::job_t    q_data,
	output logic             empty,
	input  logic             pop,
	output sjf_pkg::result_t rdata
);
	import sjf_pkg::*;

	localparam int unsigned IW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
	localparam int unsigned CW = $clog2(MAX_PROCS + 1);

	// job store
	logic [15:0]       ids_q   [MAX_PROCS];
	logic [15:0]       arr_q   [MAX_PROCS];
	logic [13:0]       bur_q   [MAX_PROCS];
	logic [TIME_W-1:0] comp_q  [MAX_PROCS];
	logic [MAX_PROCS-1:0] done_q;

	state_t            state_q, state_d;
	logic [CW-1:0]     cnt_q;
	logic [CW-1:0]     left_q;
	logic [CW-1:0]     idx_q;
	logic [TIME_W-1:0] time_q;
	logic              pick_v_q;
	logic [IW-1:0]     pick_q;
	logic [13:0]       pick_b_q;
	logic [16:0]       next_arr_q;
	logic [SUM_W-1:0]  sw_q, st_q;
	result_t           out_q;
	logic              out_v_q;

	logic [IW-1:0]     ix;
	logic              arrived;
	logic [TIME_W:0]   tsum;
	logic [TIME_W-1:0] tnew;
	logic [TIME_W-1:0] tat, wt;
	logic [SUM_W:0]    swn, stn;
	logic              scan_end;

	assign ix       = idx_q[IW-1:0];
	assign arrived  = ({2'b0, arr_q[ix]} <= time_q);
	assign scan_end = (idx_q + CW'(1) == cnt_q);
	assign tsum     = {1'b0, time_q} + (TIME_W+1)'(bur_q[pick_q]);
	assign tnew     = tsum[TIME_W] ? TIME_MAX : tsum[TIME_W-1:0];
	assign tat      = comp_q[ix] - TIME_W'(arr_q[ix]);
	assign wt       = (tat > TIME_W'(bur_q[ix])) ? tat - TIME_W'(bur_q[ix]) : '0;
	assign swn      = {1'b0, sw_q} + (SUM_W+1)'(wt);
	assign stn      = {1'b0, st_q} + (SUM_W+1)'(tat);

	assign empty = !out_v_q;
	assign rdata = out_q;

	// next state
	always_comb begin
		state_d = state_q;
		q_take  = 1'b0;
		case (state_q)
			ST_LOAD: begin
				q_take = q_valid;
				if (q_valid && q_data.last_job) begin
					if (cnt_q != '0 || MAX_PROCS != 0) state_d = ST_SCAN;
				end
			end
			ST_SCAN:   if (scan_end) state_d = ST_APPLY;
			ST_APPLY:  state_d = (pick_v_q && left_q == CW'(1)) ? ST_REPORT : ST_SCAN;
			ST_REPORT: if (!out_v_q || pop) state_d = ST_EMIT;
			ST_EMIT:   state_d = scan_end ? ST_LOAD : ST_REPORT;
			default:   state_d = ST_LOAD;
		endcase
	end

	// store writes
	always_ff @(posedge clk) begin
		if (state_q == ST_LOAD && q_valid && cnt_q < CW'(MAX_PROCS)) begin
			ids_q[cnt_q[IW-1:0]] <= q_data.job_id;
			arr_q[cnt_q[IW-1:0]] <= q_data.arrival_time;
			bur_q[cnt_q[IW-1:0]] <= q_data.burst_time;
		end
		if (state_q == ST_APPLY && pick_v_q) comp_q[pick_q] <= tnew;
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_LOAD;
			cnt_q    <= '0;
			left_q   <= '0;
			idx_q    <= '0;
			time_q   <= '0;
			done_q   <= '0;
			pick_v_q <= 1'b0;
			pick_q   <= '0;
			pick_b_q <= '0;
			next_arr_q <= '1;
			sw_q     <= '0;
			st_q     <= '0;
			out_v_q  <= 1'b0;
			out_q    <= '0;
		end else begin
			state_q <= state_d;
			// the report state refills the register on the same pop
			if (pop && out_v_q && state_q != ST_REPORT) out_v_q <= 1'b0;
			case (state_q)
				ST_LOAD: if (q_valid) begin
					logic [CW-1:0] nc;
					nc = (cnt_q < CW'(MAX_PROCS)) ? cnt_q + CW'(1) : cnt_q;
					cnt_q <= nc;
					if (cnt_q < CW'(MAX_PROCS)) done_q[cnt_q[IW-1:0]] <= 1'b0;
					if (q_data.last_job) begin
						left_q     <= nc;
						idx_q      <= '0;
						time_q     <= '0;
						pick_v_q   <= 1'b0;
						next_arr_q <= '1;
					end
				end
				ST_SCAN: begin
					if (!done_q[ix]) begin
						if (arrived) begin
							if (!pick_v_q || bur_q[ix] < pick_b_q) begin
								pick_v_q <= 1'b1;
								pick_q   <= ix;
								pick_b_q <= bur_q[ix];
							end
						end else if ({1'b0, arr_q[ix]} < next_arr_q) begin
							next_arr_q <= {1'b0, arr_q[ix]};
						end
					end
					idx_q <= idx_q + CW'(1);
				end
				ST_APPLY: begin
					if (pick_v_q) begin
						time_q         <= tnew;
						done_q[pick_q] <= 1'b1;
						left_q         <= left_q - CW'(1);
					end else begin
						time_q <= TIME_W'(next_arr_q[15:0]);
					end
					pick_v_q   <= 1'b0;
					next_arr_q <= '1;
					idx_q      <= '0;
					sw_q       <= '0;
					st_q       <= '0;
				end
				ST_REPORT: if (!out_v_q || pop) begin
					out_v_q <= 1'b1;
					out_q.out_job_id      <= ids_q[ix];
					out_q.completion_time <= comp_q[ix];
					out_q.turnaround_time <= tat;
					out_q.waiting_time    <= wt;
					out_q.sum_waiting     <= swn[SUM_W] ? SUM_MAX : swn[SUM_W-1:0];
					out_q.sum_turnaround  <= stn[SUM_W] ? SUM_MAX : stn[SUM_W-1:0];
					out_q.last_result     <= scan_end;
					sw_q <= swn[SUM_W] ? SUM_MAX : swn[SUM_W-1:0];
					st_q <= stn[SUM_W] ? SUM_MAX : stn[SUM_W-1:0];
				end
				ST_EMIT: begin
					idx_q <= idx_q + CW'(1);
					if (scan_end) begin
						cnt_q  <= '0;
						done_q <= '0;
						time_q <= '0;
					end
				end
				default: ;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= CW'(MAX_PROCS))
		else $error("job count beyond capacity");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (idx_q < cnt_q))
		else $error("scan index out of range");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LOAD) |-> (done_q == '0))
		else $error("done flags not clear while loading");
endmodule

// ===== rtl/core/sjf_nonpreemptive_scheduler_top.sv =====
// After the last job word, each scheduling step scans the stored entries and then
// passes the apply state; idle gaps add steps. Results then leave in load order
// through the report and emit states, stalling while an earlier result waits for pop.
// No job word of the next set is taken until the last result has passed the emit state.
// Reset: arst_n clears queues, counters, done flags and the result register.
// Job words keep queuing in the front end while the back end is busy.
module sjf_nonpreemptive_scheduler_top #(
	parameter int unsigned MAX_PROCS = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  sjf_pkg::job_t    in_word,
	output logic             empty,
	input  logic             pop,
	output sjf_pkg::result_t out_word
);
	import sjf_pkg::*;

	logic q_valid, q_take;
	job_t q_data;

	sjf_front u_front (
		.clk, .arst_n, .push, .full, .wdata(in_word),
		.q_valid, .q_take, .q_data
	);

	sjf_core #(.MAX_PROCS(MAX_PROCS)) u_core (
		.clk, .arst_n, .q_valid, .q_take, .q_data,
		.empty, .pop, .rdata(out_word)
	);
endmodule

// ===== tb/tb_sjf_nonpreemptive_scheduler_top.sv =====
// Self-checking testbench for the non-preemptive shortest-job-first scheduler.
`timescale 1ns / 100ps

module tb_sjf_nonpreemptive_scheduler_top;
	import sjf_pkg::*;

	localparam int unsigned NPROC = 16;
	localparam int unsigned STALL_LIMIT = 4000000;
	localparam int unsigned N_ITEMS = 500;

	logic clk;
	logic arst_n;
	logic push;
	logic full;
	job_t in_word;
	logic empty;
	logic pop;
	result_t out_word;

	sjf_nonpreemptive_scheduler_top #(.MAX_PROCS(NPROC)) dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .in_word(in_word),
		.empty(empty), .pop(pop), .out_word(out_word)
	);

	// job table of the predictor
	logic [15:0] tbl_id [NPROC];
	logic [15:0] tbl_arr [NPROC];
	logic [13:0] tbl_burst [NPROC];
	logic [17:0] tbl_done_at [NPROC];
	bit tbl_done [NPROC];
	int unsigned tbl_count;

	job_t pending_jobs[$];
	result_t expected_reports[$];
	int unsigned n_jobs_in, n_reports, n_sets, n_mism;
	int unsigned idle_cycles;

	// store one job; on the last job of a set, schedule and queue the reports
	task automatic sjf_predict(input job_t j);
		int unsigned now, left, pick, next_arr, ct, tat, wt, sw, st;
		result_t r;
		if (tbl_count < NPROC) begin
			tbl_id[tbl_count] = j.job_id;
			tbl_arr[tbl_count] = j.arrival_time;
			tbl_burst[tbl_count] = j.burst_time;
			tbl_done[tbl_count] = 0;
			tbl_count++;
		end
		if (!j.last_job)
			return;
		now = 0;
		left = tbl_count;
		while (left > 0) begin
			pick = tbl_count;
			next_arr = 32'hffff_ffff;
			for (int i = 0; i < tbl_count; i++) begin
				if (tbl_done[i])
					continue;
				if (tbl_arr[i] <= now) begin
					if (pick == tbl_count || tbl_burst[i] < tbl_burst[pick])
						pick = i;
				end else if (tbl_arr[i] < next_arr) begin
					next_arr = tbl_arr[i];
				end
			end
			if (pick == tbl_count) begin
				now = next_arr;
				continue;
			end
			now = now + tbl_burst[pick];
			if (now > TIME_MAX)
				now = TIME_MAX;
			tbl_done_at[pick] = 18'(now);
			tbl_done[pick] = 1;
			left--;
		end
		sw = 0;
		st = 0;
		for (int i = 0; i < tbl_count; i++) begin
			ct = tbl_done_at[i];
			tat = ct - tbl_arr[i];
			wt = (tat > tbl_burst[i]) ? tat - tbl_burst[i] : 0;
			sw = (sw + wt > SUM_MAX) ? SUM_MAX : sw + wt;
			st = (st + tat > SUM_MAX) ? SUM_MAX : st + tat;
			r.out_job_id = tbl_id[i];
			r.completion_time = TIME_W'(ct);
			r.turnaround_time = TIME_W'(tat);
			r.waiting_time = TIME_W'(wt);
			r.sum_waiting = SUM_W'(sw);
			r.sum_turnaround = SUM_W'(st);
			r.last_result = (i + 1 == tbl_count);
			expected_reports.push_back(r);
		end
		for (int i = 0; i < NPROC; i++)
			tbl_done[i] = 0;
		tbl_count = 0;
		n_sets++;
	endtask

	task automatic add_job(input int unsigned id, input int unsigned arr,
			input int unsigned bt, input bit last);
		job_t j;
		j.job_id = 16'(id);
		j.arrival_time = 16'(arr);
		j.burst_time = 14'(bt);
		j.last_job = last;
		pending_jobs.push_back(j);
	endtask

	// clock
	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// stimulus
	initial begin
		int unsigned n, total;
		bit wide;
		tbl_count = 0;
		for (int i = 0; i < NPROC; i++)
			tbl_done[i] = 0;
		arst_n = 0;
		// zero burst, single job
		add_job(16'h0000, 0, 0, 1);
		// ties on burst, late start forces idle ticks
		add_job(16'h1111, 5, 7, 0);
		add_job(16'h2222, 3, 7, 0);
		add_job(16'h3333, 5, 7, 0);
		add_job(16'h4444, 9, 2, 1);
		// over capacity: the extra jobs are dropped, the last one still starts
		for (int i = 0; i < 18; i++)
			add_job(i, 0, 16383 - i, i == 17);
		// latest arrivals and largest bursts: time saturates
		for (int i = 0; i < 16; i++)
			add_job(16'hffff, 16'hffff, 14'h3fff, i == 15);
		total = pending_jobs.size();
		// random sets, small arrivals to keep idle ticking short
		while (total < N_ITEMS) begin
			n = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 20) : $urandom_range(1, 16);
			wide = ($urandom_range(0, 3) == 0);
			for (int i = 0; i < n; i++)
				add_job($urandom_range(0, 65535), $urandom_range(0, 300),
					wide ? $urandom_range(0, 16383) : $urandom_range(0, 60), i == n - 1);
			total += n;
		end
		repeat (12) @(posedge clk);
		arst_n <= 1;
	end

	// driver: bursts of words with random gaps
	int unsigned burst_left, gap_left;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			push <= 0;
			in_word <= '0;
			burst_left = 0;
			gap_left = 0;
		end else begin
			if (push && !full) begin
				sjf_predict(in_word);
				n_jobs_in++;
			end
			if (!(push && full)) begin
				if (burst_left == 0 && gap_left == 0) begin
					burst_left = $urandom_range(1, 24);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
				end
				if (burst_left > 0 && pending_jobs.size() > 0) begin
					in_word <= pending_jobs.pop_front();
					push <= 1;
					burst_left--;
				end else begin
					push <= 0;
					if (gap_left > 0)
						gap_left--;
				end
			end
		end
	end

	// monitor: check each report word, stall on a pop mode that is redrawn at random
	int unsigned stall_mode, cyc;
	always @(posedge clk or negedge arst_n) begin
		result_t e;
		if (!arst_n) begin
			pop <= 0;
			cyc = 0;
			stall_mode = 0;
		end else begin
			if (pop && !empty) begin
				n_reports++;
				if (expected_reports.size() == 0) begin
					n_mism++;
					if (n_mism <= 10)
						$display("unexpected report word %h", out_word);
				end else begin
					e = expected_reports.pop_front();
					if (out_word !== e) begin
						n_mism++;
						if (n_mism <= 10) begin
							$display({"report mismatch: exp id=%h ct=%0d tat=%0d wt=%0d",
								" sw=%0d st=%0d last=%b"},
								e.out_job_id, e.completion_time, e.turnaround_time,
								e.waiting_time, e.sum_waiting, e.sum_turnaround,
								e.last_result);
							$display({"                 got id=%h ct=%0d tat=%0d wt=%0d",
								" sw=%0d st=%0d last=%b"},
								out_word.out_job_id, out_word.completion_time,
								out_word.turnaround_time, out_word.waiting_time,
								out_word.sum_waiting, out_word.sum_turnaround,
								out_word.last_result);
						end
					end
				end
			end
			cyc++;
			if (cyc % 64 == 0)
				stall_mode = $urandom_range(0, 2);
			case (stall_mode)
				0: pop <= 1;
				1: pop <= 1'($urandom_range(0, 1));
				default: pop <= ($urandom_range(0, 9) == 0);
			endcase
		end
	end

	// watchdog on cycles without any accepted word
	always @(posedge clk) begin
		if (arst_n) begin
			if ((push && !full) || (pop && !empty))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("timeout: no progress for %0d cycles", idle_cycles);
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	// end of run
	initial begin
		wait (arst_n);
		wait (pending_jobs.size() == 0 && !push && expected_reports.size() == 0);
		repeat (100) @(posedge clk);
		$display("covered %0d job words in %0d sets, %0d report words checked",
			n_jobs_in, n_sets, n_reports);
		$display("includes zero bursts, ties, overflowing sets and saturated time");
		if (n_mism == 0 && expected_reports.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/core/sjf_pkg.sv
rtl/core/sjf_front.sv
rtl/core/sjf_core.sv
rtl/core/sjf_nonpreemptive_scheduler_top.sv
tb/tb_sjf_nonpreemptive_scheduler_top.sv
